// File: hw/rtl/pcc_pkg.sv
// ---------------------------------------------------------------------------
// pcc_pkg - shared types and constants of the palette color cycler
// Color table, group layout, register map and controller/datapath bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    localparam int NUM_TIMERS = 4;
    localparam int NUM_GROUPS = 6;

    // register map (word index)
    localparam logic [2:0] REG_CYCLE_ENABLE = 3'd0;
    localparam logic [2:0] REG_SPEED_FACTOR = 3'd1;
    localparam logic [2:0] REG_PERIOD_SLOW  = 3'd2;
    localparam logic [2:0] REG_PERIOD_FAST  = 3'd3;
    localparam logic [2:0] REG_PERIOD_SCRN  = 3'd4;
    localparam logic [2:0] REG_PERIOD_PULSE = 3'd5;

    // input kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // color groups in emission order
    localparam logic [2:0] GRP_SLIME     = 3'd0;
    localparam logic [2:0] GRP_SHORE     = 3'd1;
    localparam logic [2:0] GRP_FIRE_SLOW = 3'd2;
    localparam logic [2:0] GRP_FIRE_FAST = 3'd3;
    localparam logic [2:0] GRP_SCREENS   = 3'd4;
    localparam logic [2:0] GRP_PULSE     = 3'd5;

    localparam logic [5:0] PULSE_TOP  = 6'd60;
    localparam logic [5:0] PULSE_STEP = 6'd4;

    typedef struct packed {
        logic              cycle_enable;
        logic [7:0]        speed_factor;
        logic [3:0][15:0]  period;        // timer four .. timer one
    } pcc_cfg_t;

    typedef struct packed {
        logic restart;   // clear the timestamps
        logic load;      // capture the tick time
        logic mult;      // thresholds and elapsed times
        logic check;     // timer compare, stamp update, first group
        logic step;      // emit one entry
    } pcc_cmd_t;

    typedef struct packed {
        logic any_due;
        logic last_step;
        logic slot_free;
    } pcc_sts_t;

    typedef struct packed {
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
    } pcc_rgb_t;

    function automatic logic [7:0] grp_entry(input logic [2:0] grp);
        logic [7:0] e;
        unique case (grp)
            GRP_SLIME:     e = 8'd229;
            GRP_SHORE:     e = 8'd248;
            GRP_FIRE_SLOW: e = 8'd238;
            GRP_FIRE_FAST: e = 8'd243;
            GRP_SCREENS:   e = 8'd233;
            GRP_PULSE:     e = 8'd254;
            default:       e = 8'd0;
        endcase
        return e;
    endfunction

    function automatic logic [2:0] grp_size(input logic [2:0] grp);
        logic [2:0] s;
        unique case (grp)
            GRP_SLIME:     s = 3'd4;
            GRP_SHORE:     s = 3'd6;
            GRP_FIRE_SLOW: s = 3'd5;
            GRP_FIRE_FAST: s = 3'd5;
            GRP_SCREENS:   s = 3'd5;
            GRP_PULSE:     s = 3'd1;
            default:       s = 3'd1;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] grp_color_base(input logic [2:0] grp);
        logic [4:0] b;
        unique case (grp)
            GRP_SLIME:     b = 5'd0;
            GRP_SHORE:     b = 5'd4;
            GRP_FIRE_SLOW: b = 5'd10;
            GRP_FIRE_FAST: b = 5'd15;
            GRP_SCREENS:   b = 5'd20;
            default:       b = 5'd0;
        endcase
        return b;
    endfunction

    // 6-bit colors, one entry per palette color
    function automatic pcc_rgb_t color_rom(input logic [4:0] idx);
        pcc_rgb_t c;
        unique case (idx)
            5'd0:    c = '{6'd0,  6'd27, 6'd0};
            5'd1:    c = '{6'd2,  6'd28, 6'd1};
            5'd2:    c = '{6'd6,  6'd30, 6'd3};
            5'd3:    c = '{6'd10, 6'd32, 6'd6};
            5'd4:    c = '{6'd20, 6'd15, 6'd10};
            5'd5:    c = '{6'd18, 6'd14, 6'd10};
            5'd6:    c = '{6'd16, 6'd13, 6'd9};
            5'd7:    c = '{6'd15, 6'd12, 6'd9};
            5'd8:    c = '{6'd13, 6'd11, 6'd8};
            5'd9:    c = '{6'd12, 6'd10, 6'd8};
            5'd10:   c = '{6'd63, 6'd0,  6'd0};
            5'd11:   c = '{6'd53, 6'd0,  6'd0};
            5'd12:   c = '{6'd36, 6'd10, 6'd2};
            5'd13:   c = '{6'd63, 6'd29, 6'd0};
            5'd14:   c = '{6'd63, 6'd14, 6'd0};
            5'd15:   c = '{6'd17, 6'd0,  6'd0};
            5'd16:   c = '{6'd30, 6'd0,  6'd0};
            5'd17:   c = '{6'd44, 6'd0,  6'd0};
            5'd18:   c = '{6'd30, 6'd0,  6'd0};
            5'd19:   c = '{6'd17, 6'd0,  6'd0};
            5'd20:   c = '{6'd26, 6'd26, 6'd27};
            5'd21:   c = '{6'd24, 6'd25, 6'd31};
            5'd22:   c = '{6'd21, 6'd26, 6'd35};
            5'd23:   c = '{6'd0,  6'd36, 6'd40};
            5'd24:   c = '{6'd26, 6'd46, 6'd63};
            default: c = '{6'd0,  6'd0,  6'd0};
        endcase
        return c;
    endfunction

    // lowest set bit of mask at or above start: {found, index}
    function automatic logic [3:0] next_grp(input logic [5:0] mask, input logic [2:0] start);
        logic       found;
        logic [2:0] idx;
        found = 1'b0;
        idx   = 3'd0;
        for (int i = 0; i < NUM_GROUPS; i++) begin
            if (!found && (3'(i) >= start) && mask[i]) begin
                found = 1'b1;
                idx   = 3'(i);
            end
        end
        return {found, idx};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pcc_ctrl.sv
// ---------------------------------------------------------------------------
// pcc_ctrl - sequencer of the palette color cycler
// Takes one transaction at a time and steps the datapath through
// threshold, compare and entry emission.
// ---------------------------------------------------------------------------
`default_nettype none

module pcc_ctrl
    import pcc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_kind,
    input  wire logic     cycle_enable,
    input  wire pcc_sts_t sts,
    output logic          in_ready,
    output pcc_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MULT  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == KIND_RESTART)
                    begin
                        cmd.restart = 1'b1;
                    end
                    else if (cycle_enable)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_MULT;
                    end
                end
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.any_due ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.step = sts.slot_free;
                if (sts.slot_free && sts.last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pcc_dp.sv
// ---------------------------------------------------------------------------
// pcc_dp - datapath of the palette color cycler
// Timestamps, timer thresholds, group offsets, red pulse and the output
// register that holds one palette entry.
// ---------------------------------------------------------------------------
`default_nettype none

module pcc_dp
    import pcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pcc_cmd_t    cmd,
    input  wire pcc_cfg_t    cfg,
    input  wire logic [31:0] in_time,
    input  wire logic        out_ready,
    output pcc_sts_t         sts,
    output logic             out_valid,
    output logic [7:0]       out_entry,
    output pcc_rgb_t         out_rgb,
    output logic             out_last
);

    logic [31:0] stamp_reg   [NUM_TIMERS];
    logic [31:0] elapsed_reg [NUM_TIMERS];
    logic [23:0] thresh_reg  [NUM_TIMERS];
    logic [31:0] now_reg;
    logic [5:0]  gmask_reg;
    logic [2:0]  group_reg;
    logic [2:0]  k_reg;
    logic [2:0]  offset_reg  [NUM_GROUPS];
    logic [5:0]  level_reg;
    logic        rising_reg;

    logic        out_valid_reg;
    logic [7:0]  out_entry_reg;
    pcc_rgb_t    out_rgb_reg;
    logic        out_last_reg;

    logic [NUM_TIMERS-1:0] due;
    logic [5:0]  gmask;
    logic [3:0]  first;
    logic [3:0]  following;
    logic [2:0]  size;
    logic        group_end;
    logic [3:0]  rot_sum;
    logic [2:0]  rot_idx;
    logic        rising_next;
    logic [5:0]  level_next;
    logic [7:0]  entry;
    pcc_rgb_t    rgb;

    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            due[i] = elapsed_reg[i] >= {8'd0, thresh_reg[i]};
        end
    end

    // timer one drives three groups
    assign gmask     = {due[3], due[2], due[1], due[0], due[0], due[0]};
    assign first     = next_grp(gmask, GRP_SLIME);
    assign following = next_grp(gmask_reg, group_reg + 3'd1);

    assign size      = grp_size(group_reg);
    assign group_end = (k_reg == size - 3'd1);

    // (offset + k) mod size, both below size
    assign rot_sum = {1'b0, offset_reg[group_reg]} + {1'b0, k_reg};
    assign rot_idx = (rot_sum >= {1'b0, size}) ? 3'(rot_sum - {1'b0, size}) : rot_sum[2:0];

    // direction flips at either end before the step
    assign rising_next = ((level_reg == 6'd0) || (level_reg == PULSE_TOP)) ? ~rising_reg
                                                                            : rising_reg;
    assign level_next  = rising_next ? level_reg + PULSE_STEP : level_reg - PULSE_STEP;

    assign entry = grp_entry(group_reg) + {5'd0, k_reg};

    always_comb
    begin
        if (group_reg == GRP_PULSE)
        begin
            rgb = '{level_next, 6'd0, 6'd0};
        end
        else
        begin
            rgb = color_rom(grp_color_base(group_reg) + {2'd0, rot_idx});
        end
    end

    assign sts.any_due   = |due;
    assign sts.last_step = group_end && !following[3];
    assign sts.slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                stamp_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                offset_reg[i] <= '0;
            end
            level_reg     <= '0;
            rising_reg    <= 1'b0;
            group_reg     <= '0;
            k_reg         <= '0;
            gmask_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    stamp_reg[i] <= '0;
                end
            end
            if (cmd.check)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (due[i])
                    begin
                        stamp_reg[i] <= now_reg;
                    end
                end
                gmask_reg <= gmask;
                group_reg <= first[2:0];
                k_reg     <= '0;
            end
            if (cmd.step)
            begin
                if (group_end)
                begin
                    k_reg     <= '0;
                    group_reg <= following[2:0];
                    if (group_reg == GRP_PULSE)
                    begin
                        level_reg  <= level_next;
                        rising_reg <= rising_next;
                    end
                    else
                    begin
                        offset_reg[group_reg] <= (offset_reg[group_reg] == 3'd0)
                                                 ? size - 3'd1
                                                 : offset_reg[group_reg] - 3'd1;
                    end
                end
                else
                begin
                    k_reg <= k_reg + 3'd1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= in_time;
        end
        if (cmd.mult)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                thresh_reg[i]  <= {8'd0, cfg.period[i]} * {16'd0, cfg.speed_factor};
                elapsed_reg[i] <= now_reg - stamp_reg[i];
            end
        end
        if (cmd.step)
        begin
            out_entry_reg <= entry;
            out_rgb_reg   <= rgb;
            out_last_reg  <= group_end && !following[3];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_entry = out_entry_reg;
    assign out_rgb   = out_rgb_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/palette_color_cycler.sv
// A tick passes through capture, threshold multiply and timer compare before
// its first palette entry is registered; entries then leave one per cycle,
// up to 26, as the downstream side takes them.
// Restart and disabled ticks emit nothing.
// Reset (rst_n low, asynchronous) clears stamps, offsets and pulse; registers
// return to enable 1, speed 1, periods 200/142/100/33.
// ---------------------------------------------------------------------------
// palette_color_cycler - timed palette color cycling
// Four timers rotate palette color groups and drive a red pulse entry.
// ---------------------------------------------------------------------------
`default_nettype none

module palette_color_cycler
    import pcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input transactions
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] now_time
    input  wire logic        s_tuser,   // [0] kind
    // palette entries
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] entry_index, [13:8] red,
                                        // [19:14] green, [25:20] blue, zero above
    output logic             m_tlast,   // last_entry
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        cycle_enable_reg;
    logic [7:0]  speed_factor_reg;
    logic [15:0] period_slow_reg;
    logic [15:0] period_fast_reg;
    logic [15:0] period_scrn_reg;
    logic [15:0] period_pulse_reg;

    logic        wr_en;
    logic [2:0]  reg_idx;
    pcc_cfg_t    cfg;
    pcc_cmd_t    cmd;
    pcc_sts_t    sts;
    logic [7:0]  out_entry;
    pcc_rgb_t    out_rgb;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_enable_reg <= 1'b1;
            speed_factor_reg <= 8'd1;
            period_slow_reg  <= 16'd200;
            period_fast_reg  <= 16'd142;
            period_scrn_reg  <= 16'd100;
            period_pulse_reg <= 16'd33;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CYCLE_ENABLE: cycle_enable_reg <= pwdata[0];
                REG_SPEED_FACTOR: speed_factor_reg <= pwdata[7:0];
                REG_PERIOD_SLOW:  period_slow_reg  <= pwdata[15:0];
                REG_PERIOD_FAST:  period_fast_reg  <= pwdata[15:0];
                REG_PERIOD_SCRN:  period_scrn_reg  <= pwdata[15:0];
                REG_PERIOD_PULSE: period_pulse_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CYCLE_ENABLE: prdata = {31'd0, cycle_enable_reg};
            REG_SPEED_FACTOR: prdata = {24'd0, speed_factor_reg};
            REG_PERIOD_SLOW:  prdata = {16'd0, period_slow_reg};
            REG_PERIOD_FAST:  prdata = {16'd0, period_fast_reg};
            REG_PERIOD_SCRN:  prdata = {16'd0, period_scrn_reg};
            REG_PERIOD_PULSE: prdata = {16'd0, period_pulse_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.cycle_enable = cycle_enable_reg;
    assign cfg.speed_factor = speed_factor_reg;
    assign cfg.period       = {period_pulse_reg, period_scrn_reg,
                               period_fast_reg, period_slow_reg};

    pcc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_kind      (s_tuser),
        .cycle_enable (cycle_enable_reg),
        .sts          (sts),
        .in_ready     (s_tready),
        .cmd          (cmd)
    );

    pcc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .in_time   (s_tdata),
        .out_ready (m_tready),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_entry (out_entry),
        .out_rgb   (out_rgb),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'd0, out_rgb.blue, out_rgb.green, out_rgb.red, out_entry};

endmodule

`default_nettype wire

// File: tb/sv/palette_color_cycler_tb.sv
// ---------------------------------------------------------------------------
// palette_color_cycler_tb - self-checking bench for the palette color cycler
// Sends tick and restart transactions while the APB side is stepped through
// enable, speed and period settings. A scoreboard rotates its own copy of the
// color groups and the red pulse, then matches every palette entry in order.
// ---------------------------------------------------------------------------
module palette_color_cycler_tb;
    import pcc_pkg::*;

    localparam int TIMER_SLOW    = 0;
    localparam int TIMER_FAST    = 1;
    localparam int TIMER_SCREENS = 2;
    localparam int TIMER_PULSE   = 3;
    localparam int DRAIN_CYCLES  = 4000;

    // {red, green, blue}, 6 bits each
    localparam logic [17:0] PALETTE [25] = '{
        {6'd0,  6'd27, 6'd0},  {6'd2,  6'd28, 6'd1},  {6'd6,  6'd30, 6'd3},
        {6'd10, 6'd32, 6'd6},
        {6'd20, 6'd15, 6'd10}, {6'd18, 6'd14, 6'd10}, {6'd16, 6'd13, 6'd9},
        {6'd15, 6'd12, 6'd9},  {6'd13, 6'd11, 6'd8},  {6'd12, 6'd10, 6'd8},
        {6'd63, 6'd0,  6'd0},  {6'd53, 6'd0,  6'd0},  {6'd36, 6'd10, 6'd2},
        {6'd63, 6'd29, 6'd0},  {6'd63, 6'd14, 6'd0},
        {6'd17, 6'd0,  6'd0},  {6'd30, 6'd0,  6'd0},  {6'd44, 6'd0,  6'd0},
        {6'd30, 6'd0,  6'd0},  {6'd17, 6'd0,  6'd0},
        {6'd26, 6'd26, 6'd27}, {6'd24, 6'd25, 6'd31}, {6'd21, 6'd26, 6'd35},
        {6'd0,  6'd36, 6'd40}, {6'd26, 6'd46, 6'd63}
    };

    // indexed by group code
    localparam logic [7:0] GROUP_ENTRY [6] = '{8'd229, 8'd248, 8'd238, 8'd243, 8'd233, 8'd254};
    localparam int         GROUP_SIZE  [6] = '{4, 6, 5, 5, 5, 1};
    localparam int         GROUP_BASE  [6] = '{0, 4, 10, 15, 20, 0};

    typedef struct {
        logic [7:0] entry;
        pcc_rgb_t   rgb;
        logic       last;
    } palette_entry_t;

    class palette_scoreboard;
        bit             enable;
        bit [7:0]       speed;
        bit [15:0]      period [4];
        bit [31:0]      stamp [4];
        bit [2:0]       offset [6];
        bit [5:0]       level;
        bit             rising;
        palette_entry_t expected [$];
        palette_entry_t burst [$];
        int             errors;

        function new();
            enable                = 1'b1;
            speed                 = 8'd1;
            period[TIMER_SLOW]    = 16'd200;
            period[TIMER_FAST]    = 16'd142;
            period[TIMER_SCREENS] = 16'd100;
            period[TIMER_PULSE]   = 16'd33;
            foreach (stamp[i]) stamp[i] = '0;
            foreach (offset[i]) offset[i] = '0;
            level  = '0;
            rising = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_CYCLE_ENABLE: enable = value[0];
                REG_SPEED_FACTOR: speed = value[7:0];
                REG_PERIOD_SLOW, REG_PERIOD_FAST, REG_PERIOD_SCRN, REG_PERIOD_PULSE:
                    period[idx - REG_PERIOD_SLOW] = value[15:0];
                default: ;
            endcase
        endfunction

        function bit timer_due(int t, logic [31:0] now_ms);
            bit [31:0] elapsed;
            bit [31:0] threshold;
            elapsed   = now_ms - stamp[t];
            threshold = period[t] * speed;
            if (elapsed >= threshold) begin
                stamp[t] = now_ms;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void rotate_group(logic [2:0] grp);
            palette_entry_t e;
            int             size;
            int             off;
            size = GROUP_SIZE[grp];
            off  = offset[grp] % size;
            for (int k = 0; k < size; k++) begin
                e.entry = 8'(GROUP_ENTRY[grp] + k);
                e.rgb   = pcc_rgb_t'(PALETTE[GROUP_BASE[grp] + (off + k) % size]);
                e.last  = 1'b0;
                burst.push_back(e);
            end
            offset[grp] = 3'((off == 0) ? size - 1 : off - 1);
        endfunction

        function void note_input(logic kind, logic [31:0] now_ms);
            palette_entry_t e;
            if (kind == KIND_RESTART) begin
                foreach (stamp[i]) stamp[i] = '0;
                return;
            end
            if (!enable)
                return;
            burst.delete();
            if (timer_due(TIMER_SLOW, now_ms)) begin
                rotate_group(GRP_SLIME);
                rotate_group(GRP_SHORE);
                rotate_group(GRP_FIRE_SLOW);
            end
            if (timer_due(TIMER_FAST, now_ms))
                rotate_group(GRP_FIRE_FAST);
            if (timer_due(TIMER_SCREENS, now_ms))
                rotate_group(GRP_SCREENS);
            if (timer_due(TIMER_PULSE, now_ms)) begin
                // direction flips at either end before stepping
                if (level == 6'd0 || level == PULSE_TOP)
                    rising = !rising;
                level = rising ? level + PULSE_STEP : level - PULSE_STEP;
                e.entry     = GROUP_ENTRY[GRP_PULSE];
                e.rgb.red   = level;
                e.rgb.green = '0;
                e.rgb.blue  = '0;
                e.last      = 1'b0;
                burst.push_back(e);
            end
            foreach (burst[i]) begin
                e      = burst[i];
                e.last = (i == burst.size() - 1);
                expected.push_back(e);
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_result(logic [31:0] data, logic last);
            palette_entry_t e;
            if (expected.size() == 0) begin
                report($sformatf("unexpected entry %0d data %h", data[7:0], data));
                return;
            end
            e = expected.pop_front();
            if (data[7:0] !== e.entry || data[13:8] !== e.rgb.red
                    || data[19:14] !== e.rgb.green || data[25:20] !== e.rgb.blue
                    || data[31:26] !== 6'd0 || last !== e.last)
                report($sformatf({"got entry %0d rgb %0d/%0d/%0d last %b pad %h, ",
                                  "want entry %0d rgb %0d/%0d/%0d last %b"},
                                 data[7:0], data[13:8], data[19:14], data[25:20], last,
                                 data[31:26], e.entry, e.rgb.red, e.rgb.green,
                                 e.rgb.blue, e.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] now_time
    logic        s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [7:0] entry_index, [13:8] red, [19:14] green, [25:20] blue
    logic        m_tlast;   // last_entry
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    palette_scoreboard sb;
    int                idle_max;
    logic [31:0]       clock_ms;

    palette_color_cycler DUT (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // both handshakes are sampled here, on pre-edge values
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
        end
    end

    // downstream stalls
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_item(input logic kind, input logic [31:0] stamp_ms);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= stamp_ms;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic tick(input logic [31:0] stamp_ms);
        send_item(KIND_TICK, stamp_ms);
    endtask

    // stop sending and let every pending entry and any silent tick finish
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic write_periods(input logic [15:0] slow, input logic [15:0] fast,
                                 input logic [15:0] scrn, input logic [15:0] pulse);
        write_reg(REG_PERIOD_SLOW, {16'd0, slow});
        write_reg(REG_PERIOD_FAST, {16'd0, fast});
        write_reg(REG_PERIOD_SCRN, {16'd0, scrn});
        write_reg(REG_PERIOD_PULSE, {16'd0, pulse});
    endtask

    // mostly advancing time, with restarts, jumps and near-wrap values mixed in
    task automatic run_traffic(input int count, input int step_max);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_item(KIND_RESTART, $urandom);
            end else if (pick < 12) begin
                clock_ms = $urandom;
                tick(clock_ms);
            end else if (pick < 15) begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max);
                tick(clock_ms);
            end else begin
                clock_ms = clock_ms + $urandom_range(0, step_max);
                tick(clock_ms);
            end
        end
    endtask

    initial begin
        sb       = new();
        idle_max = 12;
        clock_ms = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: thresholds 200/142/100/33
        tick(32'd0);
        tick(32'd33);
        tick(32'd142);
        tick(32'd200);
        tick(32'hFFFF_FFFF);
        send_item(KIND_RESTART, 32'hFFFF_FFFF);
        tick(32'd0);
        tick(32'd199);

        // disabled: ticks are silent but a restart still clears the stamps
        settle();
        write_reg(REG_CYCLE_ENABLE, 32'd0);
        tick(32'hFFFF_FFFF);
        send_item(KIND_RESTART, 32'd0);
        tick(32'hFFFF_FFFF);
        settle();
        write_reg(REG_CYCLE_ENABLE, 32'd1);
        tick(32'd250);

        // zero speed: every timer fires on the same time value
        settle();
        write_reg(REG_SPEED_FACTOR, 32'd0);
        repeat (3) tick(32'd250);

        settle();
        write_reg(REG_SPEED_FACTOR, 32'd255);
        write_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick(32'hFFFF_FFFF);
        tick(32'h0000_0100);

        settle();
        write_reg(REG_SPEED_FACTOR, 32'd1);
        write_periods(16'd200, 16'd142, 16'd100, 16'd33);
        clock_ms = 32'd300;
        run_traffic(60, 250);

        // back to back, full bursts every tick
        settle();
        idle_max = 0;
        write_reg(REG_SPEED_FACTOR, 32'd0);
        run_traffic(30, 50);

        settle();
        idle_max = 12;
        write_reg(REG_SPEED_FACTOR, 32'd255);
        write_periods(16'd1, 16'd2, 16'd3, 16'd1);
        run_traffic(50, 900);

        settle();
        write_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        run_traffic(40, 40_000_000);

        settle();
        idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
        write_reg(REG_SPEED_FACTOR, $urandom_range(1, 4));
        write_periods(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                      16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
        run_traffic(60, 700);

        settle();
        idle_max = 12;
        write_reg(REG_CYCLE_ENABLE, 32'd0);
        run_traffic(20, 300);

        settle();
        write_reg(REG_CYCLE_ENABLE, 32'd1);
        write_reg(REG_SPEED_FACTOR, 32'd1);
        write_periods(16'd200, 16'd142, 16'd100, 16'd33);
        run_traffic(20, 250);

        settle();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d palette entries never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/pcc_pkg.sv
hw/rtl/pcc_ctrl.sv
hw/rtl/pcc_dp.sv
hw/rtl/palette_color_cycler.sv
tb/sv/palette_color_cycler_tb.sv
